FILE: sv/rtu_pkg.sv
// Rectangle transform unit: shared types, codes and constants.
// No dependencies; imported by the interfaces and all rtu modules.
package rtu_pkg;

    localparam logic [2:0] ACT_LOAD    = 3'd0;
    localparam logic [2:0] ACT_MOVE    = 3'd1;
    localparam logic [2:0] ACT_MOVE_TO = 3'd2;
    localparam logic [2:0] ACT_SCALE   = 3'd3;
    localparam logic [2:0] ACT_ROTATE  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD_W = 2'd1;
    localparam logic [1:0] ST_BAD_H = 2'd2;
    localparam logic [1:0] ST_BAD_F = 2'd3;

    localparam logic signed [25:0] DEG_FULL    = 26'sd23592960;
    localparam logic signed [25:0] DEG_HALF    = 26'sd11796480;
    localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;
    localparam logic signed [25:0] DEG_3QUART  = 26'sd17694720;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [5:0]         ROOT_TOP = 6'd32;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] span_x;
        logic signed [31:0] span_y;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [23:0] factor;
        logic signed [25:0] turn_degrees;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        box_width;
        logic [31:0]        box_height;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic [47:0]        area;
    } t_res;

    typedef struct packed {
        logic       capture;
        logic       simple;
        logic       ang_mod;
        logic       ang_fold;
        logic       cordic_step;
        logic [4:0] idx;
        logic       trig;
        logic       mul;
        logic [1:0] phase;
        logic [2:0] sel;
        logic       commit;
        logic       sq;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic [5:0] root_bit;
        logic       area_mul;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       err;
        logic       out_busy;
    } t_stat;

    // arctan(2^-i) in degrees, Q16.16
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/rtu_if.sv
// Rectangle transform unit: valid/ready channel interfaces for items and results.
// Depends on rtu_pkg.
interface rtu_in_if import rtu_pkg::*;;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] span_x;
    logic signed [31:0] span_y;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [23:0] factor;
    logic signed [25:0] turn_degrees;
    modport source(output valid, action, span_x, span_y, coord_x, coord_y, factor,
                   turn_degrees, input ready);
    modport sink(input valid, action, span_x, span_y, coord_x, coord_y, factor,
                 turn_degrees, output ready);
endinterface

interface rtu_out_if import rtu_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        box_width;
    logic [31:0]        box_height;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic [47:0]        area;
    modport source(output valid, status, box_width, box_height, centre_x, centre_y, area,
                   input ready);
    modport sink(input valid, status, box_width, box_height, centre_x, centre_y, area,
                 output ready);
endinterface

FILE: sv/rtu_ctrl.sv
// Rectangle transform unit: sequencing state machine and step counters.
// Depends on rtu_pkg; drives rtu_dp through t_cmd.
module rtu_ctrl import rtu_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int         N_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] LAST    = 5'(N_STEPS - 1);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DISP   = 13'b0000000000010,
        S_AMOD   = 13'b0000000000100,
        S_AFOLD  = 13'b0000000001000,
        S_CORD   = 13'b0000000010000,
        S_TRIG   = 13'b0000000100000,
        S_MUL    = 13'b0000001000000,
        S_COMMIT = 13'b0000010000000,
        S_SQ     = 13'b0000100000000,
        S_RINIT  = 13'b0001000000000,
        S_ROOT   = 13'b0010000000000,
        S_AMUL   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_ph, n_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ph    = r_ph;
        o_cmd.idx      = r_cnt[4:0];
        o_cmd.sel      = r_cnt[2:0];
        o_cmd.phase    = r_ph;
        o_cmd.sq_sel   = r_cnt[1:0];
        o_cmd.root_bit = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_cnt = '0;
                n_ph  = '0;
                if (i_stat.err) begin
                    n_state = S_SQ;
                end else begin
                    unique case (i_stat.action)
                        ACT_LOAD, ACT_MOVE, ACT_MOVE_TO: begin
                            o_cmd.simple = 1'b1;
                            n_state = S_SQ;
                        end
                        ACT_SCALE:  n_state = S_MUL;
                        ACT_ROTATE: n_state = S_AMOD;
                        default:    n_state = S_SQ;
                    endcase
                end
            end
            S_AMOD: begin
                o_cmd.ang_mod = 1'b1;
                n_state = S_AFOLD;
            end
            S_AFOLD: begin
                o_cmd.ang_fold = 1'b1;
                n_cnt = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                o_cmd.cordic_step = 1'b1;
                if (r_cnt[4:0] == LAST) begin
                    n_state = S_TRIG;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_cnt = '0;
                n_ph  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_ph == 2'd2) begin
                    n_ph = '0;
                    if (r_cnt[2:0] == 3'd7) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_cnt = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_RINIT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_RINIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt = ROOT_TOP;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_AMUL;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_AMUL: begin
                o_cmd.area_mul = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: sv/rtu_dp.sv
// Rectangle transform unit: corner registers, CORDIC, shared multiplier,
// square root lanes and result register. Depends on rtu_pkg; driven by rtu_ctrl.
module rtu_dp import rtu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_item i_item,
    output t_stat o_stat,
    output t_res  o_res,
    output logic  o_res_valid,
    input  logic  i_res_ready
);

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) r = 32'sh7fffffff;
        else if (v < -68'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] min4(input logic signed [31:0] a, b, c, d);
        logic signed [31:0] m0, m1;
        m0 = (a < b) ? a : b;
        m1 = (c < d) ? c : d;
        return (m0 < m1) ? m0 : m1;
    endfunction

    function automatic logic signed [31:0] max4(input logic signed [31:0] a, b, c, d);
        logic signed [31:0] m0, m1;
        m0 = (a > b) ? a : b;
        m1 = (c > d) ? c : d;
        return (m0 > m1) ? m0 : m1;
    endfunction

    t_item              r_it;
    logic signed [31:0] r_cx [4];
    logic signed [31:0] r_cy [4];
    logic signed [31:0] r_sh [8];
    logic signed [25:0] r_z;
    logic               r_neg;
    logic signed [33:0] r_x, r_y, r_c, r_s;
    logic signed [67:0] r_prod, r_acc;
    logic [65:0]        r_sum  [2];
    logic [35:0]        r_rem  [2];
    logic [32:0]        r_root [2];
    t_res               r_res;
    logic               r_ov;

    // bounding box
    logic signed [31:0] w_mnx, w_mxx, w_mny, w_mxy, w_cenx, w_ceny;
    logic signed [32:0] w_extx, w_exty, w_tx, w_ty;

    assign w_mnx  = min4(r_cx[0], r_cx[1], r_cx[2], r_cx[3]);
    assign w_mxx  = max4(r_cx[0], r_cx[1], r_cx[2], r_cx[3]);
    assign w_mny  = min4(r_cy[0], r_cy[1], r_cy[2], r_cy[3]);
    assign w_mxy  = max4(r_cy[0], r_cy[1], r_cy[2], r_cy[3]);
    assign w_extx = 33'(w_mxx) - 33'(w_mnx);
    assign w_exty = 33'(w_mxy) - 33'(w_mny);
    assign w_tx   = 33'(w_mnx) + (w_extx >>> 1);
    assign w_ty   = 33'(w_mny) + (w_exty >>> 1);
    assign w_cenx = w_tx[31:0];
    assign w_ceny = w_ty[31:0];

    // status
    logic [1:0] w_status;
    always_comb begin
        w_status = ST_OK;
        if (r_it.action == ACT_LOAD) begin
            if ($signed(r_it.span_x) <= 0) w_status = ST_BAD_W;
            else if ($signed(r_it.span_y) <= 0) w_status = ST_BAD_H;
        end else if (r_it.action == ACT_SCALE) begin
            if ($signed(r_it.factor) <= 0) w_status = ST_BAD_F;
        end
    end

    assign o_stat.action   = r_it.action;
    assign o_stat.err      = (w_status != ST_OK);
    assign o_stat.out_busy = r_ov;

    // load placement
    logic signed [33:0] w_l, w_r, w_b, w_t, w_ox, w_oy;
    assign w_l  = 34'(r_it.coord_x) - 34'(r_it.span_x >>> 1);
    assign w_r  = w_l + 34'(r_it.span_x);
    assign w_b  = 34'(r_it.coord_y) - 34'(r_it.span_y >>> 1);
    assign w_t  = w_b + 34'(r_it.span_y);
    assign w_ox = (r_it.action == ACT_MOVE) ? 34'(r_it.coord_x)
                                             : 34'(r_it.coord_x) - 34'(w_cenx);
    assign w_oy = (r_it.action == ACT_MOVE) ? 34'(r_it.coord_y)
                                             : 34'(r_it.coord_y) - 34'(w_ceny);

    // shared multiplier
    logic [1:0]         w_k;
    logic signed [33:0] w_dx, w_dy, w_d0, w_d1, w_d2, w_d3;
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic               w_rot;

    assign w_k   = i_cmd.sel[1:0];
    assign w_dx  = 34'(r_cx[w_k]) - 34'(w_cenx);
    assign w_dy  = 34'(r_cy[w_k]) - 34'(w_ceny);
    assign w_d0  = 34'(r_cx[1]) - 34'(r_cx[0]);
    assign w_d1  = 34'(r_cy[1]) - 34'(r_cy[0]);
    assign w_d2  = 34'(r_cx[1]) - 34'(r_cx[2]);
    assign w_d3  = 34'(r_cy[1]) - 34'(r_cy[2]);
    assign w_rot = (r_it.action == ACT_ROTATE);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        priority if (i_cmd.sq) begin
            unique case (i_cmd.sq_sel)
                2'd0: w_ma = (w_d0 < 0) ? -w_d0 : w_d0;
                2'd1: w_ma = (w_d1 < 0) ? -w_d1 : w_d1;
                2'd2: w_ma = (w_d2 < 0) ? -w_d2 : w_d2;
                default: w_ma = (w_d3 < 0) ? -w_d3 : w_d3;
            endcase
            w_mb = w_ma;
        end else if (i_cmd.area_mul) begin
            w_ma = $signed({1'b0, r_root[0]});
            w_mb = $signed({1'b0, r_root[1]});
        end else if (i_cmd.mul) begin
            if (w_rot) begin
                if (i_cmd.phase == 2'd0) begin
                    w_ma = w_dx;
                    w_mb = i_cmd.sel[2] ? r_s : r_c;
                end else begin
                    w_ma = w_dy;
                    w_mb = i_cmd.sel[2] ? r_c : -r_s;
                end
            end else if (i_cmd.phase == 2'd0) begin
                w_ma = i_cmd.sel[2] ? w_dy : w_dx;
                w_mb = 34'(r_it.factor);
            end
        end
    end

    assign w_prod = w_ma * w_mb;

    // corner update after products
    logic signed [67:0] w_tot, w_rnd;
    logic signed [31:0] w_new;
    assign w_tot = r_acc + r_prod;
    assign w_rnd = w_rot ? ((w_tot + 68'sd134217728) >>> 28) : ((w_tot + 68'sd32768) >>> 16);
    assign w_new = sat32(68'(i_cmd.sel[2] ? w_ceny : w_cenx) + w_rnd);

    // angle and CORDIC
    logic signed [25:0] w_zm, w_a, w_fold;
    logic               w_fneg;
    logic signed [33:0] w_sx, w_sy, w_xr, w_yr;
    logic signed [25:0] w_at;

    always_comb begin
        if (r_it.turn_degrees < 0) w_zm = r_it.turn_degrees + DEG_FULL;
        else if (r_it.turn_degrees >= DEG_FULL) w_zm = r_it.turn_degrees - DEG_FULL;
        else w_zm = r_it.turn_degrees;
        w_a = (r_z < 0) ? r_z + DEG_FULL : r_z;
        if (w_a <= DEG_QUARTER) begin
            w_fold = w_a;
            w_fneg = 1'b0;
        end else if (w_a < DEG_3QUART) begin
            w_fold = w_a - DEG_HALF;
            w_fneg = 1'b1;
        end else begin
            w_fold = w_a - DEG_FULL;
            w_fneg = 1'b0;
        end
    end

    assign w_sx = r_y >>> i_cmd.idx;
    assign w_sy = r_x >>> i_cmd.idx;
    assign w_at = $signed({4'b0, atan_deg(i_cmd.idx)});
    assign w_xr = (r_x + 34'sd2) >>> 2;
    assign w_yr = (r_y + 34'sd2) >>> 2;

    // square root lanes
    logic [1:0]  w_pair [2];
    logic [35:0] w_remn [2];
    logic [35:0] w_trial [2];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_pair[l]  = 2'(r_sum[l] >> {i_cmd.root_bit, 1'b0});
            w_remn[l]  = {r_rem[l][33:0], w_pair[l]};
            w_trial[l] = {1'b0, r_root[l], 2'b01};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cx[k] <= '0;
                r_cy[k] <= '0;
            end
        end else if (i_cmd.simple) begin
            for (int k = 0; k < 4; k++) begin
                if (r_it.action == ACT_LOAD) begin
                    r_cx[k] <= sat32(68'((k == 0 || k == 3) ? w_l : w_r));
                    r_cy[k] <= sat32(68'((k < 2) ? w_t : w_b));
                end else begin
                    r_cx[k] <= sat32(68'(r_cx[k]) + 68'(w_ox));
                    r_cy[k] <= sat32(68'(r_cy[k]) + 68'(w_oy));
                end
            end
        end else if (i_cmd.commit) begin
            for (int k = 0; k < 4; k++) begin
                r_cx[k] <= r_sh[k];
                r_cy[k] <= r_sh[k + 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_it <= i_item;
        if (i_cmd.ang_mod) r_z <= w_zm;
        if (i_cmd.ang_fold) begin
            r_z   <= w_fold;
            r_neg <= w_fneg;
            r_x   <= GAIN_Q30;
            r_y   <= '0;
        end
        if (i_cmd.cordic_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_sx;
                r_y <= r_y + w_sy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_sx;
                r_y <= r_y - w_sy;
                r_z <= r_z + w_at;
            end
        end
        if (i_cmd.trig) begin
            r_c <= r_neg ? -w_xr : w_xr;
            r_s <= r_neg ? -w_yr : w_yr;
        end
        if (i_cmd.mul) begin
            unique case (i_cmd.phase)
                2'd0: r_prod <= w_prod;
                2'd1: begin
                    r_acc  <= r_prod;
                    r_prod <= w_prod;
                end
                default: r_sh[i_cmd.sel] <= w_new;
            endcase
        end
        if (i_cmd.sq) begin
            r_prod <= w_prod;
            if (i_cmd.sq_sel[0]) r_acc <= r_prod;
            if (i_cmd.sq_sel == 2'd2) r_sum[0] <= 66'(w_tot);
        end
        if (i_cmd.area_mul) r_prod <= w_prod;
        if (i_cmd.root_init) begin
            r_sum[1] <= 66'(w_tot);
            for (int l = 0; l < 2; l++) begin
                r_rem[l]  <= '0;
                r_root[l] <= '0;
            end
        end
        if (i_cmd.root_step) begin
            for (int l = 0; l < 2; l++) begin
                if (w_remn[l] >= w_trial[l]) begin
                    r_rem[l]  <= w_remn[l] - w_trial[l];
                    r_root[l] <= {r_root[l][31:0], 1'b1};
                end else begin
                    r_rem[l]  <= w_remn[l];
                    r_root[l] <= {r_root[l][31:0], 1'b0};
                end
            end
        end
        if (i_cmd.finish) begin
            r_res.status     <= w_status;
            r_res.box_width  <= w_extx[31:0];
            r_res.box_height <= w_exty[31:0];
            r_res.centre_x   <= w_cenx;
            r_res.centre_y   <= w_ceny;
            r_res.area       <= (|r_prod[67:64]) ? '1 : r_prod[63:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_ov;

endmodule

FILE: sv/rectangle_transform_unit_top.sv
// Rectangle transform unit, top level: channel interfaces, controller and datapath.
// Depends on rtu_pkg, rtu_if, rtu_ctrl and rtu_dp.
//
// i_in carries one action per transfer (load, move, move to point, scale,
// rotate); o_res returns exactly one result per item: status, axis-aligned
// bounding box of the four corners and the area from the two side lengths.
// Items are handled one at a time; i_in.ready is high only while the block
// waits for an item. The rotation sines come from one iterative CORDIC stage
// (one step a cycle), the new corners from one shared multiplier, and the
// side lengths from two square root lanes, one result bit a cycle.
// The result sits in an output register; the next item is taken while it
// waits, and a finished item holds in the controller until the receiver has
// taken the previous result, so a stall never drops or repeats a transfer.
// Reset (synchronous, active low) clears all corners to zero and empties
// the output register.
module rectangle_transform_unit_top import rtu_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rtu_in_if.sink   i_in,
    rtu_out_if.source o_res
);

    t_cmd  w_cmd;
    t_stat w_stat;
    t_item w_item;
    t_res  w_res;
    logic  w_in_ready;
    logic  w_res_valid;

    assign w_item.action       = i_in.action;
    assign w_item.span_x       = i_in.span_x;
    assign w_item.span_y       = i_in.span_y;
    assign w_item.coord_x      = i_in.coord_x;
    assign w_item.coord_y      = i_in.coord_y;
    assign w_item.factor       = i_in.factor;
    assign w_item.turn_degrees = i_in.turn_degrees;
    assign i_in.ready          = w_in_ready;

    rtu_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rtu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (w_item),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready)
    );

    assign o_res.valid      = w_res_valid;
    assign o_res.status     = w_res.status;
    assign o_res.box_width  = w_res.box_width;
    assign o_res.box_height = w_res.box_height;
    assign o_res.centre_x   = w_res.centre_x;
    assign o_res.centre_y   = w_res.centre_y;
    assign o_res.area       = w_res.area;

endmodule

FILE: bench/rectangle_transform_unit_top_tb.sv
// Testbench for rectangle_transform_unit_top: directed and random actions on the item
// channel, every result checked against a local fixed-point predictor of the corners.
// Depends on rtu_pkg, rtu_if and the RTL of the block.
module rectangle_transform_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtu_pkg::*;

    localparam int STEPS = 16;

    logic i_clk;
    logic i_rst_n;
    rtu_in_if  item_ch();
    rtu_out_if res_ch();

    rectangle_transform_unit_top #(.CORDIC_STEPS(STEPS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(item_ch.sink), .o_res(res_ch.source)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    longint box_x[4];
    longint box_y[4];
    t_res   expected_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_stall_pct;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mid_of(longint p[4]);
        longint mn, mx;
        mn = p[0]; mx = p[0];
        for (int k = 1; k < 4; k++) begin
            if (p[k] < mn) mn = p[k];
            if (p[k] > mx) mx = p[k];
        end
        return mn + ((mx - mn) >>> 1);
    endfunction

    function automatic int atan_tab(int i);
        int tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return (i < 23) ? tab[i] : 0;
    endfunction

    function automatic void sin_cos(longint deg, output longint c, output longint s);
        longint full, half, quart, a, x, y, z, dx, dy, t;
        bit     flip;
        full = 360 * 65536; half = 180 * 65536; quart = 90 * 65536;
        a = deg % full;
        flip = 0;
        if (a < 0) a += full;
        if (a > half) a -= full;
        if (a > quart) begin
            a -= half; flip = 1;
        end else if (a < -quart) begin
            a += half; flip = 1;
        end
        x = 652032874; y = 0; z = a;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            t = longint'(atan_tab(i));
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        x = (x + 2) >>> 2;
        y = (y + 2) >>> 2;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [63:0] side_root(int i, int j);
        longint      dx, dy;
        logic [66:0] sq, rem, trial;
        logic [63:0] root;
        dx = box_x[i] - box_x[j]; dy = box_y[i] - box_y[j];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = 67'(dx) * 67'(dx) + 67'(dy) * 67'(dy);
        root = 0; rem = 0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | ((sq >> (2 * k)) & 67'd3);
            trial = 67'((root << 2) | 64'd1);
            if (rem >= trial) begin
                rem -= trial; root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic t_res corner_update(t_item it);
        t_res        r;
        longint      cx, cy, l, b, dx, dy, c, s, mnx, mxx, mny, mxy;
        logic [63:0] w, h;
        logic [127:0] prod;
        cx = mid_of(box_x); cy = mid_of(box_y);
        r = '0;
        r.status = ST_OK;
        case (it.action)
            ACT_LOAD: begin
                if (it.span_x <= 0) r.status = ST_BAD_W;
                else if (it.span_y <= 0) r.status = ST_BAD_H;
                else begin
                    l = longint'(it.coord_x) - (longint'(it.span_x) >>> 1);
                    b = longint'(it.coord_y) - (longint'(it.span_y) >>> 1);
                    box_x[0] = clamp32(l); box_x[3] = box_x[0];
                    box_x[1] = clamp32(l + it.span_x); box_x[2] = box_x[1];
                    box_y[2] = clamp32(b); box_y[3] = box_y[2];
                    box_y[0] = clamp32(b + it.span_y); box_y[1] = box_y[0];
                end
            end
            ACT_MOVE, ACT_MOVE_TO: begin
                dx = it.coord_x; dy = it.coord_y;
                if (it.action == ACT_MOVE_TO) begin
                    dx -= cx; dy -= cy;
                end
                for (int k = 0; k < 4; k++) begin
                    box_x[k] = clamp32(box_x[k] + dx);
                    box_y[k] = clamp32(box_y[k] + dy);
                end
            end
            ACT_SCALE: begin
                if (it.factor <= 0) r.status = ST_BAD_F;
                else for (int k = 0; k < 4; k++) begin
                    box_x[k] = clamp32(cx + (((box_x[k] - cx) * it.factor + 32768) >>> 16));
                    box_y[k] = clamp32(cy + (((box_y[k] - cy) * it.factor + 32768) >>> 16));
                end
            end
            ACT_ROTATE: begin
                sin_cos(longint'(it.turn_degrees), c, s);
                for (int k = 0; k < 4; k++) begin
                    dx = box_x[k] - cx; dy = box_y[k] - cy;
                    box_x[k] = clamp32(cx + ((c * dx - s * dy + (64'sd1 << 27)) >>> 28));
                    box_y[k] = clamp32(cy + ((s * dx + c * dy + (64'sd1 << 27)) >>> 28));
                end
            end
            default: ;
        endcase
        mnx = box_x[0]; mxx = mnx; mny = box_y[0]; mxy = mny;
        for (int k = 1; k < 4; k++) begin
            if (box_x[k] < mnx) mnx = box_x[k];
            if (box_x[k] > mxx) mxx = box_x[k];
            if (box_y[k] < mny) mny = box_y[k];
            if (box_y[k] > mxy) mxy = box_y[k];
        end
        w = side_root(1, 0);
        h = side_root(1, 2);
        prod = 128'(w) * 128'(h);
        r.area = (prod >> 64 != 0) ? 48'hFFFF_FFFF_FFFF : 48'(prod >> 16);
        r.box_width  = 32'(mxx - mnx);
        r.box_height = 32'(mxy - mny);
        r.centre_x   = 32'(mnx + ((mxx - mnx) >>> 1));
        r.centre_y   = 32'(mny + ((mxy - mny) >>> 1));
        return r;
    endfunction

    // valid stays high after a transfer so back-to-back items need no second
    // assignment in the same time step; idle cycles and the end drop it
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= it.action;
        item_ch.span_x       <= it.span_x;
        item_ch.span_y       <= it.span_y;
        item_ch.coord_x      <= it.coord_x;
        item_ch.coord_y      <= it.coord_y;
        item_ch.factor       <= it.factor;
        item_ch.turn_degrees <= it.turn_degrees;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        expected_q.push_back(corner_update(it));
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.status, res_ch.box_width, res_ch.box_height,
                    res_ch.centre_x, res_ch.centre_y, res_ch.area};
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result %p", $time, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_item rand_item(int act);
        t_item it;
        it.action       = 3'(act);
        it.span_x       = $urandom;
        it.span_y       = $urandom;
        it.coord_x      = $urandom;
        it.coord_y      = $urandom;
        it.factor       = 24'($urandom);
        it.turn_degrees = 26'($urandom);
        return it;
    endfunction

    function automatic t_item sane_item();
        t_item it;
        int    act;
        act = $urandom_range(4);
        it = rand_item(act);
        it.span_x  = $urandom_range(32'h0100_0000, 1);
        it.span_y  = $urandom_range(32'h0100_0000, 1);
        it.coord_x = $signed(32'($urandom_range(32'h0200_0000))) - 32'sh0100_0000;
        it.coord_y = $signed(32'($urandom_range(32'h0200_0000))) - 32'sh0100_0000;
        it.factor  = 24'($urandom_range(24'h03_0000, 1));
        if ($urandom_range(3) == 0) it.turn_degrees = 26'($urandom_range(720) * 65536);
        return it;
    endfunction

    task automatic test_directed();
        t_item it;
        int    angles[8] = '{0, 90, 180, -90, 270, 360, -180, 45};
        it = rand_item(ACT_LOAD); it.span_x = 0; send_item(it);
        it.span_x = 32'sh8000_0000; send_item(it);
        it.span_x = 65536; it.span_y = 0; send_item(it);
        it.span_y = -1; send_item(it);
        it = '{ACT_LOAD, 32'sd655360, 32'sd327680, 32'sd0, 32'sd0, 24'sd0, 26'sd0};
        send_item(it);
        it.action = ACT_SCALE; it.factor = 24'sd0; send_item(it);
        it.factor = 24'sh80_0000; send_item(it);
        it.factor = 24'sh7F_FFFF; send_item(it);
        it.factor = 24'sd32768; send_item(it);
        it.action = ACT_ROTATE;
        foreach (angles[i]) begin
            it.turn_degrees = 26'(angles[i] * 65536);
            send_item(it);
        end
        it.turn_degrees = 26'sh1FF_FFFF; send_item(it);
        it.turn_degrees = 26'sh200_0000; send_item(it);
        it.action = ACT_MOVE; it.coord_x = 32'sh7FFF_FFFF; it.coord_y = 32'sh8000_0000;
        send_item(it);
        it.action = ACT_MOVE_TO; it.coord_x = 32'sh8000_0000; it.coord_y = 32'sh7FFF_FFFF;
        send_item(it);
        it = '{ACT_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
               24'sd0, 26'sd0};
        send_item(it);
        for (int a = 5; a < 8; a++) send_item(rand_item(a));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) send_item(sane_item());
            else send_item(rand_item($urandom_range(7)));
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 4; k++) begin
            box_x[k] = 0; box_y[k] = 0;
        end
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = '0;
        item_ch.span_x = '0;
        item_ch.span_y = '0;
        item_ch.coord_x = '0;
        item_ch.coord_y = '0;
        item_ch.factor = '0;
        item_ch.turn_degrees = '0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        send_idle_pct = 73;
        test_random(400);
        send_idle_pct = 0; recv_stall_pct = 73;
        test_random(400);
        send_idle_pct = 27; recv_stall_pct = 27;
        test_random(420);
        item_ch.valid <= 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
sv/rtu_pkg.sv
sv/rtu_if.sv
sv/rtu_ctrl.sv
sv/rtu_dp.sv
sv/rectangle_transform_unit_top.sv
bench/rectangle_transform_unit_top_tb.sv
